// ----- hw/rtl/rrts_pkg.sv -----
// Shared types and codes for the round-robin thread scheduler.
// No dependencies; imported by every scheduler module.
`default_nettype none

package rrts_pkg;

  // Width of a thread slot number; slot 63 marks "nothing running"
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned TICKS_W = 32;

  localparam logic [SLOT_W-1:0] NO_THREAD = 6'd63;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_DELAY = 2'd2,
    ACT_SCHED = 2'd3
  } action_e;

  // Input transaction
  typedef struct packed {
    logic [1:0]         action;
    logic [TICKS_W-1:0] ticks;
  } rrts_req_t;

  // Result transaction
  typedef struct packed {
    logic [SLOT_W-1:0] next_thread;
    logic              switch_request;
    logic              error_flag;
  } rrts_rsp_t;

  // Commands from the sequencer to the sleep timer bank
  typedef struct packed {
    logic tick;
    logic load;
  } tmr_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/round_robin_thread_scheduler_unit.sv -----
// Round-robin thread scheduler: top-level sequencer, ready mask and result register.
// Depends on rrts_pkg, rrts_timer and rrts_picker.
//
// A transaction is taken when start is high and busy is low; exactly one result
// follows, shown on rsp_o for a single cycle with done_o high, and the receiver
// must take it then. Start answers in the cycle after acceptance. Tick walks the
// sleep counters of the registered threads through one shared decrementer, one
// entry per cycle. Schedule and delay pass through a set-up step, then run the
// round-robin search one slot per cycle if any thread is registered. Delay loads
// the counter and clears the ready bit at acceptance. busy stays high until the
// result is out.
`default_nettype none

module round_robin_thread_scheduler_unit
  import rrts_pkg::*;
#(
  parameter int unsigned MAX_THREADS = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  input  wire rrts_req_t req_i,
  output logic           done_o,
  output rrts_rsp_t      rsp_o
);

  localparam int unsigned IdxW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam logic [SLOT_W-1:0] SlotLimit = SLOT_W'(MAX_THREADS + 1);
  localparam logic [SLOT_W-1:0] MaxSlot   = SLOT_W'(MAX_THREADS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_SCHED,
    ST_PICK
  } state_e;

  state_e                 state_q;
  logic [MAX_THREADS-1:0] ready_q;
  logic [SLOT_W-1:0]      rot_q;
  logic [SLOT_W-1:0]      cnt_q;
  logic [SLOT_W-1:0]      run_q;
  logic                   done_q;
  rrts_rsp_t              rsp_q;

  logic                   accept;
  logic [MAX_THREADS-1:0] reg_bits;
  logic [SLOT_W-1:0]      run_m1;
  logic [SLOT_W-1:0]      cnt_m1;
  logic                   delay_bad;
  tmr_cmd_t               tmr_cmd;
  logic                   tmr_done;
  logic                   tmr_wake;
  logic [IdxW-1:0]        tmr_wake_idx;
  logic                   pick_start;
  logic                   pick_done;
  logic [SLOT_W-1:0]      pick_idx;

  assign accept = start && !busy;
  assign busy   = state_q != ST_IDLE;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  assign run_m1    = run_q - SLOT_W'(1);
  assign cnt_m1    = cnt_q - SLOT_W'(1);
  assign delay_bad = (run_q == '0) || (run_q >= cnt_q) || (run_q > MaxSlot);

  // Mark the slots that are registered: slot n owns bit n-1
  always_comb begin
    for (int i = 0; i < MAX_THREADS; i++) begin
      reg_bits[i] = (SLOT_W'(i + 1) < cnt_q);
    end
  end

  // Drive the timer bank
  always_comb begin
    tmr_cmd.tick = accept && (req_i.action == ACT_TICK);
    tmr_cmd.load = accept && (req_i.action == ACT_DELAY) && !delay_bad;
  end

  assign pick_start = (state_q == ST_SCHED) && (cnt_q != '0);

  rrts_timer #(
    .MAX_THREADS (MAX_THREADS),
    .IdxW        (IdxW)
  ) u_timer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (tmr_cmd),
    .load_idx_i (run_m1[IdxW-1:0]),
    .load_val_i (req_i.ticks),
    .cnt_i      (cnt_q),
    .done_o     (tmr_done),
    .wake_o     (tmr_wake),
    .wake_idx_o (tmr_wake_idx)
  );

  rrts_picker #(
    .MAX_THREADS (MAX_THREADS),
    .IdxW        (IdxW)
  ) u_picker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (pick_start),
    .elig_i  (ready_q & reg_bits),
    .cnt_i   (cnt_q),
    .rot_i   (rot_q),
    .done_o  (pick_done),
    .idx_o   (pick_idx)
  );

  // Sequence each transaction and register its result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= '0;
      rot_q   <= '0;
      cnt_q   <= '0;
      run_q   <= NO_THREAD;
      done_q  <= 1'b0;
      rsp_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (req_i.action)
              ACT_START: begin
                rsp_q  <= '0;
                done_q <= 1'b1;
                if (cnt_q >= SlotLimit) begin
                  rsp_q.error_flag <= 1'b1;
                end else begin
                  if (cnt_q != '0) begin
                    ready_q[cnt_m1[IdxW-1:0]] <= 1'b1;
                  end
                  cnt_q <= cnt_q + SLOT_W'(1);
                end
              end
              ACT_TICK: begin
                state_q <= ST_TICK;
              end
              ACT_DELAY: begin
                if (delay_bad) begin
                  rsp_q            <= '0;
                  rsp_q.error_flag <= 1'b1;
                  done_q           <= 1'b1;
                end else begin
                  ready_q[run_m1[IdxW-1:0]] <= 1'b0;
                  state_q                   <= ST_SCHED;
                end
              end
              default: begin
                state_q <= ST_SCHED;
              end
            endcase
          end
        end
        ST_TICK: begin
          if (tmr_wake) begin
            ready_q[tmr_wake_idx] <= 1'b1;
          end
          if (tmr_done) begin
            rsp_q   <= '0;
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        ST_SCHED: begin
          // Nothing registered: answer idle and leave the running thread alone
          if (cnt_q == '0) begin
            rsp_q   <= '0;
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_PICK;
          end
        end
        ST_PICK: begin
          if (pick_done) begin
            rot_q                <= pick_idx;
            run_q                <= pick_idx;
            rsp_q.next_thread    <= pick_idx;
            rsp_q.switch_request <= pick_idx != run_q;
            rsp_q.error_flag     <= 1'b0;
            done_q               <= 1'b1;
            state_q              <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rrts_timer.sv -----
// Sleep counter bank with one shared decrementer that walks the entries on a tick.
// Depends on rrts_pkg.
`default_nettype none

module rrts_timer
  import rrts_pkg::*;
#(
  parameter int unsigned MAX_THREADS = 32,
  parameter int unsigned IdxW        = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tmr_cmd_t            cmd_i,
  input  wire logic [IdxW-1:0]     load_idx_i,
  input  wire logic [TICKS_W-1:0]  load_val_i,
  input  wire logic [SLOT_W-1:0]   cnt_i,
  output logic                     done_o,
  output logic                     wake_o,
  output logic [IdxW-1:0]          wake_idx_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_THREADS - 1);

  logic [TICKS_W-1:0] sleep_q [MAX_THREADS];
  logic               active_q;
  logic [IdxW-1:0]    idx_q;

  logic [SLOT_W-1:0]  slot;
  logic               entry_valid;
  logic               entry_busy;
  logic [TICKS_W-1:0] dec;

  // Current entry belongs to slot idx+1; process it only if that slot is registered
  assign slot        = SLOT_W'(idx_q) + SLOT_W'(1);
  assign entry_valid = active_q && (slot < cnt_i);
  assign entry_busy  = sleep_q[idx_q] != '0;
  assign dec         = sleep_q[idx_q] - TICKS_W'(1);

  assign wake_o     = entry_valid && entry_busy && (dec == '0);
  assign wake_idx_o = idx_q;
  assign done_o     = active_q &&
                      (!entry_valid || (idx_q == LastIdx) ||
                       ((slot + SLOT_W'(1)) >= cnt_i));

  // Hold the counters; load on delay, count down one entry per cycle on tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_THREADS; i++) begin
        sleep_q[i] <= '0;
      end
      active_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      if (cmd_i.load) begin
        sleep_q[load_idx_i] <= load_val_i;
      end
      if (cmd_i.tick) begin
        active_q <= 1'b1;
        idx_q    <= '0;
      end else if (active_q) begin
        if (entry_valid && entry_busy) begin
          sleep_q[idx_q] <= dec;
        end
        if (done_o) begin
          active_q <= 1'b0;
        end else begin
          idx_q <= idx_q + IdxW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rrts_picker.sv -----
// Round-robin search over the eligible mask, one slot per cycle.
// Depends on rrts_pkg.
`default_nettype none

module rrts_picker
  import rrts_pkg::*;
#(
  parameter int unsigned MAX_THREADS = 32,
  parameter int unsigned IdxW        = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [MAX_THREADS-1:0] elig_i,
  input  wire logic [SLOT_W-1:0]      cnt_i,
  input  wire logic [SLOT_W-1:0]      rot_i,
  output logic                        done_o,
  output logic [SLOT_W-1:0]           idx_o
);

  logic              active_q;
  logic [SLOT_W-1:0] idx_q;

  logic [SLOT_W-1:0] inc;
  logic [SLOT_W-1:0] nxt;
  logic [SLOT_W-1:0] nxt_m1;
  logic              none;
  logic              hit;

  // Advance with wrap from the last registered slot back to slot 1
  assign inc    = idx_q + SLOT_W'(1);
  assign nxt    = (inc >= cnt_i) ? SLOT_W'(1) : inc;
  assign nxt_m1 = nxt - SLOT_W'(1);
  assign none   = elig_i == '0;
  assign hit    = elig_i[nxt_m1[IdxW-1:0]];

  assign done_o = active_q && (none || hit);
  assign idx_o  = none ? '0 : nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      if (start_i) begin
        active_q <= 1'b1;
        idx_q    <= rot_i;
      end else if (active_q) begin
        idx_q <= nxt;
        if (done_o) begin
          active_q <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire
